[rtl/dqvs_pkg.sv]
package dqvs_pkg;

   // default geometry
   localparam int DQVS_DEPTH   = 16;
   localparam int DQVS_VALUE_W = 32;
   localparam int DQVS_CNT_W   = $clog2(DQVS_DEPTH + 1);

   // fixed field widths of the channels
   localparam int ACTION_W = 3;
   localparam int ITEM_W   = 32;

   localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_SEARCH     = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_REMOVE     = 3'd5;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_FRONT,
      S_BACK,
      S_DONE
   } state_type;

endpackage

[rtl/dqvs_ifs.sv]
interface dqvs_req_if;
   import dqvs_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [ACTION_W-1:0]        action;
   logic signed [ITEM_W-1:0]   item_value;

   modport source (output valid, action, item_value, input ready);
   modport sink   (input valid, action, item_value, output ready);
endinterface

interface dqvs_rsp_if #(
   parameter int CNT_W = dqvs_pkg::DQVS_CNT_W
);
   import dqvs_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [1:0]                 status;
   logic                       found;
   logic signed [ITEM_W-1:0]   front_value;
   logic signed [ITEM_W-1:0]   back_value;
   logic [CNT_W-1:0]           entry_total;
   logic                       is_empty;

   modport source (output valid, status, found, front_value, back_value, entry_total,
                   is_empty, input ready);
   modport sink   (input valid, status, found, front_value, back_value, entry_total,
                   is_empty, output ready);
endinterface

[rtl/dqvs_ram.sv]
module dqvs_ram #(
   parameter int DEPTH = dqvs_pkg::DQVS_DEPTH,
   parameter int WIDTH = dqvs_pkg::DQVS_VALUE_W,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/deque_with_value_search.sv]
// Bounded double-ended queue of signed words kept in a ring of DEPTH slots.
// req_ch carries one item per request (action, item_value); rsp_ch returns
// exactly one item per request: status, found flag, front and back values,
// entry count and empty flag, all describing the queue after the request.
// Both channels use valid/ready; an item moves when both are high.
// Requests are handled one at a time by a small sequencer around a single
// slot RAM (one write port, one registered read port) and one comparator.
// Pushes, pops and unused codes pass through a front read and a back read
// of the RAM (front and back are re-read), and the back read is skipped
// when the queue is left empty; a search compares one slot per cycle, and
// a remove additionally shifts every later value one slot forward, one slot
// per cycle. req_ch.ready is high only while idle, so the next request is
// taken in the cycle after the result is loaded, at the earliest.
// The result sits in an output register, so the next request is accepted
// and worked on while the previous result waits; if the receiver still
// stalls when the next result is ready, the sequencer holds until it
// drains. Synchronous reset empties the queue; slot contents are not
// cleared since a slot is only read after it has been written.
module deque_with_value_search #(
   parameter int DEPTH       = dqvs_pkg::DQVS_DEPTH,
   parameter int VALUE_WIDTH = dqvs_pkg::DQVS_VALUE_W
) (
   input  logic       clock,
   input  logic       reset,
   dqvs_req_if.sink   req_ch,
   dqvs_rsp_if.source rsp_ch
);
   import dqvs_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int EXT_W = (VALUE_WIDTH > ITEM_W) ? VALUE_WIDTH : ITEM_W;
   localparam logic [IDX_W:0]   DEPTH_X   = (IDX_W + 1)'(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);

   function automatic logic [IDX_W-1:0] ring_at(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] offs);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, offs};
      if (sum >= DEPTH_X) begin
         sum = sum - DEPTH_X;
      end
      return sum[IDX_W-1:0];
   endfunction

   function automatic logic [ITEM_W-1:0] to_port(input logic [VALUE_WIDTH-1:0] slot);
      logic [EXT_W-1:0] wide;
      wide = EXT_W'(slot);
      return wide[ITEM_W-1:0];
   endfunction

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       head_ff, head_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       off_ff, off_in;
   logic                   pend_ff, pend_in;
   logic [IDX_W-1:0]       pend_off_ff, pend_off_in;
   logic [ACTION_W-1:0]    act_ff, act_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   status_type             status_ff, status_in;
   logic                   found_ff, found_in;
   logic [ITEM_W-1:0]      front_ff, front_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [ITEM_W-1:0]      rsp_front_ff, rsp_front_in;
   logic [ITEM_W-1:0]      rsp_back_ff, rsp_back_in;
   logic [CNT_W-1:0]       rsp_total_ff, rsp_total_in;
   logic                   rsp_empty_ff, rsp_empty_in;

   logic                   ram_we;
   logic [IDX_W-1:0]       ram_waddr;
   logic [VALUE_WIDTH-1:0] ram_wdata;
   logic                   ram_re;
   logic [IDX_W-1:0]       ram_raddr;
   logic [VALUE_WIDTH-1:0] ram_rdata;

   logic                   req_acc;
   logic                   rsp_free;
   logic [EXT_W-1:0]       item_ext;
   logic [VALUE_WIDTH-1:0] item_v;
   logic [IDX_W-1:0]       head_dec;
   logic [CNT_W-1:0]       off_inc;
   logic [CNT_W-1:0]       cnt_dec;
   logic                   is_full;
   logic                   is_zero;
   logic                   scan_hit;
   logic                   scan_end;
   logic                   shift_end;

   dqvs_ram #(
      .DEPTH  (DEPTH),
      .WIDTH  (VALUE_WIDTH),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ch.ready = (state_ff == S_IDLE) && !reset;
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   assign item_ext  = EXT_W'(req_ch.item_value);
   assign item_v    = item_ext[VALUE_WIDTH-1:0];
   assign head_dec  = (head_ff == '0) ? LAST_IDX : head_ff - IDX_W'(1);
   assign off_inc   = off_ff + CNT_W'(1);
   assign cnt_dec   = count_ff - CNT_W'(1);
   assign is_full   = (count_ff == DEPTH_CNT);
   assign is_zero   = (count_ff == '0);
   assign scan_hit  = pend_ff && (ram_rdata == val_ff);
   assign scan_end  = !pend_ff && (off_ff >= count_ff);
   assign shift_end = !pend_ff && (off_inc >= count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               unique case (req_ch.action) inside
                  ACT_SEARCH, ACT_REMOVE: state_in = S_SCAN;
                  default:                state_in = S_FRONT;
               endcase
            end
         end
         S_SCAN: begin
            if (scan_hit) begin
               state_in = (act_ff == ACT_REMOVE) ? S_SHIFT : S_FRONT;
            end else if (scan_end) begin
               state_in = S_FRONT;
            end
         end
         S_SHIFT: begin
            if (shift_end) begin
               state_in = S_FRONT;
            end
         end
         S_FRONT: state_in = is_zero ? S_DONE : S_BACK;
         S_BACK:  state_in = S_DONE;
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      off_in      = off_ff;
      pend_in     = pend_ff;
      pend_off_in = pend_off_ff;
      act_in      = act_ff;
      val_in      = val_ff;
      status_in   = status_ff;
      found_in    = found_ff;
      front_in    = front_ff;
      ram_we      = 1'b0;
      ram_waddr   = head_ff;
      ram_wdata   = ram_rdata;
      ram_re      = 1'b0;
      ram_raddr   = head_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_front_in  = rsp_front_ff;
      rsp_back_in   = rsp_back_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_empty_in  = rsp_empty_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               act_in    = req_ch.action;
               val_in    = item_v;
               status_in = ST_OK;
               found_in  = 1'b0;
               off_in    = '0;
               pend_in   = 1'b0;
               ram_wdata = item_v;
               unique case (req_ch.action) inside
                  ACT_PUSH_FRONT: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = head_dec;
                        head_in   = head_dec;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_PUSH_BACK: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = ring_at(head_ff, count_ff[IDX_W-1:0]);
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_POP_FRONT: begin
                     if (is_zero) begin
                        status_in = ST_EMPTY;
                     end else begin
                        head_in  = ring_at(head_ff, IDX_W'(1));
                        count_in = cnt_dec;
                     end
                  end
                  ACT_POP_BACK: begin
                     if (is_zero) begin
                        status_in = ST_EMPTY;
                     end else begin
                        count_in = cnt_dec;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            // read slot off while comparing the slot read last cycle
            if (off_ff < count_ff) begin
               ram_re      = 1'b1;
               ram_raddr   = ring_at(head_ff, off_ff[IDX_W-1:0]);
               pend_in     = 1'b1;
               pend_off_in = off_ff[IDX_W-1:0];
               off_in      = off_inc;
            end else begin
               pend_in = 1'b0;
            end
            if (scan_hit) begin
               found_in = 1'b1;
               off_in   = CNT_W'(pend_off_ff);
               pend_in  = 1'b0;
            end else if (scan_end) begin
               status_in = (act_ff == ACT_REMOVE) ? ST_MISSING : ST_OK;
            end
         end
         S_SHIFT: begin
            // read slot k+1, write it into slot k in the next cycle
            if (off_inc < count_ff) begin
               ram_re      = 1'b1;
               ram_raddr   = ring_at(head_ff, off_inc[IDX_W-1:0]);
               pend_in     = 1'b1;
               pend_off_in = off_ff[IDX_W-1:0];
               off_in      = off_inc;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = ring_at(head_ff, pend_off_ff);
               ram_wdata = ram_rdata;
            end
            if (shift_end) begin
               count_in = cnt_dec;
            end
         end
         S_FRONT: begin
            if (is_zero) begin
               front_in = '0;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = head_ff;
            end
         end
         S_BACK: begin
            front_in  = to_port(ram_rdata);
            ram_re    = 1'b1;
            ram_raddr = ring_at(head_ff, cnt_dec[IDX_W-1:0]);
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_found_in  = found_ff;
               rsp_front_in  = front_ff;
               rsp_back_in   = is_zero ? '0 : to_port(ram_rdata);
               rsp_total_in  = count_ff;
               rsp_empty_in  = is_zero;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff        <= off_in;
      pend_off_ff   <= pend_off_in;
      act_ff        <= act_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      front_ff      <= front_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_front_ff  <= rsp_front_in;
      rsp_back_ff   <= rsp_back_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.found       = rsp_found_ff;
   assign rsp_ch.front_value = rsp_front_ff;
   assign rsp_ch.back_value  = rsp_back_ff;
   assign rsp_ch.entry_total = rsp_total_ff;
   assign rsp_ch.is_empty    = rsp_empty_ff;
endmodule

[rtl/dqvs_chk.sv]
module dqvs_chk #(
   parameter int DEPTH = dqvs_pkg::DQVS_DEPTH,
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [1:0]                  rsp_status,
   input logic                        rsp_found,
   input logic [dqvs_pkg::ITEM_W-1:0] rsp_front_value,
   input logic [dqvs_pkg::ITEM_W-1:0] rsp_back_value,
   input logic [CNT_W-1:0]            rsp_entry_total,
   input logic                        rsp_is_empty
);
   import dqvs_pkg::*;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   // one request in the sequencer at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous item still in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_entry_total)
          && $stable(rsp_front_value) && $stable(rsp_back_value)))
      else $error("stalled response item changed");

   a_empty_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_empty) |->
         (rsp_entry_total == '0 && rsp_front_value == '0 && rsp_back_value == '0))
      else $error("empty response with non-zero contents");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_total <= DEPTH_CNT
                     && rsp_is_empty == (rsp_entry_total == '0)))
      else $error("entry count out of range or empty flag wrong");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_status == ST_OK))
      else $error("found flag set with error status");
endmodule

bind deque_with_value_search dqvs_chk #(
   .DEPTH (DEPTH)
) u_dqvs_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_status      (rsp_ch.status),
   .rsp_found       (rsp_ch.found),
   .rsp_front_value (rsp_ch.front_value),
   .rsp_back_value  (rsp_ch.back_value),
   .rsp_entry_total (rsp_ch.entry_total),
   .rsp_is_empty    (rsp_ch.is_empty)
);
